// ===== rtl/gelu_seg3_poly_approx_macros.svh =====
// ----------------------------------------------------------------------------
// gelu_seg3_poly_approx_macros
// assertion macros shared by the gelu block; empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef GELU_SEG3_POLY_APPROX_MACROS_SVH
`define GELU_SEG3_POLY_APPROX_MACROS_SVH
`ifndef SYNTH
// plain condition, checked on every edge out of reset
`define GSP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// same-cycle or delayed implication
`define GSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);
// next-cycle implication
`define GSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GSP_ASSERT(lbl, cond, msg)
`define GSP_ASSERT_IMP(lbl, ante, cons, msg)
`define GSP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/gsp_pkg.sv =====
// ----------------------------------------------------------------------------
// gsp_pkg
// types, constants and coefficient rounding for the gelu approximation
// ----------------------------------------------------------------------------
`default_nettype none

package gsp_pkg;

  // fraction-bits register
  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd18;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // coefficient magnitudes scaled by 2^32
  localparam logic [63:0] C0_Q32   = 64'd6961320;
  localparam logic [63:0] C1_Q32   = 64'd163129928;
  localparam logic [63:0] C2_Q32   = 64'd2323813602;
  localparam logic [63:0] C3_Q32   = 64'd788234136;
  localparam logic [63:0] C4_Q32   = 64'd89544106;
  localparam logic [63:0] HALF_Q32 = 64'd2147483648;

  // range class of a shifted sample
  typedef enum logic [1:0] {
    CLS_LOW,
    CLS_MID,
    CLS_HIGH
  } cls_e;

  // control info that travels with each word
  typedef struct packed {
    cls_e             cls;
    logic [CFG_W-1:0] drop;
  } ctrl_t;

  // round a 2^32-scaled magnitude to nearest at s fraction bits
  function automatic logic [63:0] round_coef(input logic [63:0] m32, input int unsigned s);
    logic [63:0] r;
    if (s >= 32) begin
      r = m32 << (s - 32);
    end else begin
      r = (m32 + (64'd1 << (31 - s))) >> (32 - s);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gsp_front.sv =====
// ----------------------------------------------------------------------------
// gsp_front
// holds the fraction-bits register, scales each sample and classifies it
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_front #(
  parameter int WORK_FRAC  = 12,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [gsp_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic                         start_i,
  input  wire logic                         full_i,
  input  wire logic signed [DATA_WIDTH-1:0] sample_i,
  output logic                              push_o,
  output logic signed [DATA_WIDTH-1:0]      x_o,
  output gsp_pkg::ctrl_t                    ctrl_o
);

  localparam logic [gsp_pkg::CFG_W-1:0] WF = gsp_pkg::CFG_W'(WORK_FRAC);
  localparam logic signed [DATA_WIDTH-1:0] THREE = DATA_WIDTH'(3) << WORK_FRAC;
  localparam logic signed [DATA_WIDTH-1:0] NEG_THREE = -THREE;

  logic [gsp_pkg::CFG_W-1:0] frac_q;
  logic [gsp_pkg::CFG_W-1:0] frac_d;
  logic [gsp_pkg::CFG_W-1:0] drop;

  // fraction-bits register
  always_comb begin
    frac_d = frac_q;
    if (cfg_valid_i) begin
      frac_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= gsp_pkg::CFG_RESET;
    end else begin
      frac_q <= frac_d;
    end
  end

  // bits dropped on the way in
  assign drop = (frac_q > WF) ? (frac_q - WF) : '0;

  // scale down and classify
  always_comb begin
    x_o         = sample_i >>> drop;
    ctrl_o.drop = drop;
    if (x_o >= THREE) begin
      ctrl_o.cls = gsp_pkg::CLS_HIGH;
    end else if (x_o >= NEG_THREE) begin
      ctrl_o.cls = gsp_pkg::CLS_MID;
    end else begin
      ctrl_o.cls = gsp_pkg::CLS_LOW;
    end
  end

  assign push_o = start_i && !full_i;

endmodule

`default_nettype wire

// ===== rtl/gsp_queue.sv =====
// ----------------------------------------------------------------------------
// gsp_queue
// short fifo between front and back; drains one word per cycle
// ----------------------------------------------------------------------------
`default_nettype none
`include "gelu_seg3_poly_approx_macros.svh"

module gsp_queue #(
  parameter int WIDTH = 39
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam logic [gsp_pkg::QPTR_W-1:0] LAST = gsp_pkg::QPTR_W'(gsp_pkg::QDEPTH - 1);
  localparam logic [gsp_pkg::QCNT_W-1:0] FULL = gsp_pkg::QCNT_W'(gsp_pkg::QDEPTH);

  logic [WIDTH-1:0]              mem_q [gsp_pkg::QDEPTH];
  logic [gsp_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [gsp_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [gsp_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic                          pop;

  assign full_o  = (cnt_q == FULL);
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `GSP_ASSERT(q_cnt_bound, cnt_q <= FULL, "queue fill count above depth")
  `GSP_ASSERT_NXT(q_fill_up, push_i && !valid_o, cnt_q == 1, "push into empty queue lost")
  `GSP_ASSERT_NXT(q_drain, valid_o && !push_i, cnt_q == $past(cnt_q) - 1'b1,
                  "pop without push did not drain")

endmodule

`default_nettype wire

// ===== rtl/gsp_back.sv =====
// ----------------------------------------------------------------------------
// gsp_back
// four-stage pipeline: powers, coefficient products, sum, rescale
// ----------------------------------------------------------------------------
`default_nettype none
`include "gelu_seg3_poly_approx_macros.svh"

module gsp_back #(
  parameter int WORK_FRAC  = 12,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic signed [DATA_WIDTH-1:0] x_i,
  input  wire gsp_pkg::ctrl_t               ctrl_i,
  output logic                              out_valid_o,
  output logic [DATA_WIDTH-1:0]             out_value_o
);

  localparam int W   = WORK_FRAC;
  localparam int XMW = W + 3;       // signed x inside the middle range
  localparam int AW  = W + 2;       // |x|
  localparam int SQW = W + 4;       // |x|^2
  localparam int A3W = W + 5;       // |x|^3
  localparam int A4W = W + 7;       // |x|^4
  localparam int CW  = W;           // coefficients at W fraction bits
  localparam int C0W = 2 * W;       // constant term at 2W fraction bits
  localparam int SW  = 2 * W + 8;   // polynomial sum
  localparam int RW  = SW - W;      // sum after the final shift

  localparam logic [63:0] HALF_R = gsp_pkg::round_coef(gsp_pkg::HALF_Q32, W);
  localparam logic [63:0] C0_R   = gsp_pkg::round_coef(gsp_pkg::C0_Q32, 2 * W);
  localparam logic [63:0] C1_R   = gsp_pkg::round_coef(gsp_pkg::C1_Q32, W);
  localparam logic [63:0] C2_R   = gsp_pkg::round_coef(gsp_pkg::C2_Q32, W);
  localparam logic [63:0] C3_R   = gsp_pkg::round_coef(gsp_pkg::C3_Q32, W);
  localparam logic [63:0] C4_R   = gsp_pkg::round_coef(gsp_pkg::C4_Q32, W);

  localparam logic [CW-1:0]  HALF_C = HALF_R[CW-1:0];
  localparam logic [C0W-1:0] C0_C   = C0_R[C0W-1:0];
  localparam logic [CW-1:0]  C1_C   = C1_R[CW-1:0];
  localparam logic [CW-1:0]  C2_C   = C2_R[CW-1:0];
  localparam logic [CW-1:0]  C3_C   = C3_R[CW-1:0];
  localparam logic [CW-1:0]  C4_C   = C4_R[CW-1:0];

  // stage 1: |x| and |x|^2
  logic signed [XMW-1:0]        xm;
  logic [XMW-1:0]               xabs;
  logic [2*AW-1:0]              asq;
  logic                         s1_v_q;
  logic signed [DATA_WIDTH-1:0] s1_x_q;
  gsp_pkg::ctrl_t               s1_ctrl_q;
  logic signed [XMW-1:0]        s1_xm_q;
  logic [AW-1:0]                s1_a_q;
  logic [SQW-1:0]               s1_sq_q;

  assign xm   = x_i[XMW-1:0];
  assign xabs = xm[XMW-1] ? XMW'(-xm) : XMW'(xm);
  assign asq  = xabs[AW-1:0] * xabs[AW-1:0];

  always_ff @(posedge clk_i) begin
    s1_x_q    <= x_i;
    s1_ctrl_q <= ctrl_i;
    s1_xm_q   <= xm;
    s1_a_q    <= xabs[AW-1:0];
    s1_sq_q   <= asq[W+SQW-1:W];
  end

  // stage 2: |x|^3, |x|^4 and the first two coefficient products
  logic [2*SQW-1:0]             sq4;
  logic [AW+SQW-1:0]            a3p;
  logic [AW+CW-1:0]             pa1;
  logic [SQW+CW-1:0]            pa2;
  logic                         s2_v_q;
  logic signed [DATA_WIDTH-1:0] s2_x_q;
  gsp_pkg::ctrl_t               s2_ctrl_q;
  logic signed [XMW-1:0]        s2_xm_q;
  logic [A3W-1:0]               s2_a3_q;
  logic [A4W-1:0]               s2_a4_q;
  logic [AW+CW-1:0]             s2_pa1_q;
  logic [SQW+CW-1:0]            s2_pa2_q;

  assign sq4 = s1_sq_q * s1_sq_q;
  assign a3p = s1_a_q * s1_sq_q;
  assign pa1 = s1_a_q * C1_C;
  assign pa2 = s1_sq_q * C2_C;

  always_ff @(posedge clk_i) begin
    s2_x_q    <= s1_x_q;
    s2_ctrl_q <= s1_ctrl_q;
    s2_xm_q   <= s1_xm_q;
    s2_a3_q   <= a3p[W+A3W-1:W];
    s2_a4_q   <= sq4[W+A4W-1:W];
    s2_pa1_q  <= pa1;
    s2_pa2_q  <= pa2;
  end

  // stage 3: half-x term, partial sum, higher-power products
  logic signed [XMW+CW:0]       ph;
  logic signed [SW-1:0]         base;
  logic [A3W+CW-1:0]            p3;
  logic [A4W+CW-1:0]            p4;
  logic                         s3_v_q;
  logic signed [DATA_WIDTH-1:0] s3_x_q;
  gsp_pkg::ctrl_t               s3_ctrl_q;
  logic signed [SW-1:0]         s3_base_q;
  logic [A3W+CW-1:0]            s3_p3_q;
  logic [A4W+CW-1:0]            s3_p4_q;

  assign ph   = s2_xm_q * $signed({1'b0, HALF_C});
  assign base = SW'(ph) + $signed(SW'(C0_C)) - $signed(SW'(s2_pa1_q))
              + $signed(SW'(s2_pa2_q));
  assign p3   = s2_a3_q * C3_C;
  assign p4   = s2_a4_q * C4_C;

  always_ff @(posedge clk_i) begin
    s3_x_q    <= s2_x_q;
    s3_ctrl_q <= s2_ctrl_q;
    s3_base_q <= base;
    s3_p3_q   <= p3;
    s3_p4_q   <= p4;
  end

  // stage 4: final sum, range select, rescale
  logic signed [SW-1:0]         sum;
  logic signed [RW-1:0]         r;
  logic signed [DATA_WIDTH-1:0] sel;
  logic [DATA_WIDTH-1:0]        value_q;
  logic [DATA_WIDTH-1:0]        value_d;

  assign sum = s3_base_q - $signed(SW'(s3_p3_q)) + $signed(SW'(s3_p4_q));
  assign r   = sum[SW-1:W];

  always_comb begin
    case (s3_ctrl_q.cls)
      gsp_pkg::CLS_HIGH: sel = s3_x_q;
      gsp_pkg::CLS_MID:  sel = DATA_WIDTH'(r);
      gsp_pkg::CLS_LOW:  sel = '0;
      default:           sel = '0;
    endcase
    value_d = DATA_WIDTH'(sel) << s3_ctrl_q.drop;
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      s1_v_q      <= in_valid_i;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      out_valid_o <= s3_v_q;
    end
  end

  assign out_value_o = value_q;

  `GSP_ASSERT_IMP(bk_latency, in_valid_i, ##4 out_valid_o, "word lost in back pipeline")
  `GSP_ASSERT_IMP(bk_no_extra, !in_valid_i, ##4 !out_valid_o, "back pipeline made a word")

endmodule

`default_nettype wire

// ===== rtl/gelu_seg3_poly_approx.sv =====
// ----------------------------------------------------------------------------
// gelu_seg3_poly_approx
// piecewise polynomial gelu on signed fixed-point samples
// ----------------------------------------------------------------------------
// One sample is accepted per clock (start high while busy is low); the block
// sustains one word every cycle with start held high. The result strobe
// gelu_valid_o is high for one cycle, after the two-entry front queue and
// the back pipeline (powers, coefficient products, sum, rescale). Results
// cannot be held off, and since the back pipeline drains the queue every
// cycle, busy only rises if the queue is full. The fraction-bits register
// (reset 18) is written through cfg_valid_i/cfg_data_i, always ready; the
// user must write it only while the block is idle, which the block does
// not enforce; with WORK_FRAC or fewer fraction bits nothing is rescaled.
`default_nettype none

module gelu_seg3_poly_approx #(
  parameter int WORK_FRAC  = 12,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [gsp_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] sample_i,
  output logic                              gelu_valid_o,
  output logic signed [DATA_WIDTH-1:0]      gelu_value_o
);

  localparam int QW = DATA_WIDTH + $bits(gsp_pkg::ctrl_t);

  logic                         push;
  logic signed [DATA_WIDTH-1:0] fx;
  gsp_pkg::ctrl_t               fctrl;
  logic                         q_valid;
  logic [QW-1:0]                q_data;
  logic [DATA_WIDTH-1:0]        out_value;

  assign cfg_ready_o = 1'b1;

  // front: register, scale, classify
  gsp_front #(
    .WORK_FRAC  (WORK_FRAC),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .start_i     (start),
    .full_i      (busy),
    .sample_i    (sample_i),
    .push_o      (push),
    .x_o         (fx),
    .ctrl_o      (fctrl)
  );

  // queue between the halves
  gsp_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({fctrl, fx}),
    .full_o  (busy),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  // back: polynomial pipeline
  gsp_back #(
    .WORK_FRAC  (WORK_FRAC),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .x_i         ($signed(q_data[DATA_WIDTH-1:0])),
    .ctrl_i      (gsp_pkg::ctrl_t'(q_data[QW-1:DATA_WIDTH])),
    .out_valid_o (gelu_valid_o),
    .out_value_o (out_value)
  );

  assign gelu_value_o = $signed(out_value);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the piecewise polynomial gelu block: samples are
// sent over the start/busy handshake with random gaps, each accepted word is
// predicted at the current fraction-bits setting, and every strobed result
// is compared in order; the fraction-bits register is swept between phases
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORK_FRAC  = 12;
  localparam int DATA_WIDTH = 32;

  // coefficients rounded to nearest at the working precision
  localparam int     CSH    = 32 - WORK_FRAC;
  localparam int     C0SH   = 32 - 2 * WORK_FRAC;
  localparam longint K_HALF = longint'((gsp_pkg::HALF_Q32 + (64'd1 << (CSH - 1))) >> CSH);
  localparam longint K_C0   = longint'((gsp_pkg::C0_Q32 + (64'd1 << (C0SH - 1))) >> C0SH);
  localparam longint K_C1   = longint'((gsp_pkg::C1_Q32 + (64'd1 << (CSH - 1))) >> CSH);
  localparam longint K_C2   = longint'((gsp_pkg::C2_Q32 + (64'd1 << (CSH - 1))) >> CSH);
  localparam longint K_C3   = longint'((gsp_pkg::C3_Q32 + (64'd1 << (CSH - 1))) >> CSH);
  localparam longint K_C4   = longint'((gsp_pkg::C4_Q32 + (64'd1 << (CSH - 1))) >> CSH);

  localparam int NUM_PHASES   = 10;
  localparam int RANDOM_ITEMS = 140;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [gsp_pkg::CFG_W-1:0]    cfg_data_i = '0;
  logic                         start = 1'b0;
  logic                         busy;
  logic signed [DATA_WIDTH-1:0] sample_i = '0;
  logic                         gelu_valid_o;
  logic signed [DATA_WIDTH-1:0] gelu_value_o;

  // bench-side copy of the fraction-bits register
  logic [gsp_pkg::CFG_W-1:0]    frac_bits = gsp_pkg::CFG_RESET;

  logic signed [DATA_WIDTH-1:0] sample_q[$];
  logic signed [DATA_WIDTH-1:0] gelu_expect_q[$];
  int                           gap_left = 0;
  bit                           burst_mode = 1'b0;
  int                           errors = 0;

  gelu_seg3_poly_approx #(
    .WORK_FRAC (WORK_FRAC),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .start       (start),
    .busy        (busy),
    .sample_i    (sample_i),
    .gelu_valid_o(gelu_valid_o),
    .gelu_value_o(gelu_value_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // expected gelu of one sample at the given fraction bits
  function automatic logic signed [DATA_WIDTH-1:0] gelu_predict(
    input logic signed [DATA_WIDTH-1:0] s,
    input logic [gsp_pkg::CFG_W-1:0]    frac
  );
    int unsigned drop;
    longint      x, a, a2, a3, a4, acc, r, three, scaled;
    drop  = (frac > WORK_FRAC) ? frac - WORK_FRAC : 0;
    x     = longint'(s) >>> drop;
    three = longint'(3) <<< WORK_FRAC;
    if (x >= three) begin
      r = x;
    end else if (x >= -three) begin
      a   = (x < 0) ? -x : x;
      a2  = (a * a) >>> WORK_FRAC;
      a4  = (a2 * a2) >>> WORK_FRAC;
      a3  = (a * a2) >>> WORK_FRAC;
      acc = x * K_HALF + K_C0 - a * K_C1 + a2 * K_C2 - a3 * K_C3 + a4 * K_C4;
      r   = acc >>> WORK_FRAC;
    end else begin
      r = 0;
    end
    scaled = r <<< drop;
    return scaled[DATA_WIDTH-1:0];
  endfunction

  // saturate a wide value into the sample range
  function automatic logic signed [DATA_WIDTH-1:0] clip_word(input longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    lo = -(longint'(1) <<< (DATA_WIDTH - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[DATA_WIDTH-1:0];
  endfunction

  // raw value of 1.0 at the given fraction bits, or at WORK_FRAC bits if fewer
  function automatic longint unit_of(input logic [gsp_pkg::CFG_W-1:0] frac);
    return longint'(1) <<< ((frac > WORK_FRAC) ? frac : WORK_FRAC);
  endfunction

  // random sample: mostly inside the polynomial segment, some at the edges,
  // the rest anywhere in the word
  function automatic logic signed [DATA_WIDTH-1:0] pick_sample(
    input logic [gsp_pkg::CFG_W-1:0] frac
  );
    int unsigned drop, sel;
    longint      span, v, lsb;
    drop = (frac > WORK_FRAC) ? frac - WORK_FRAC : 0;
    lsb  = longint'(1) <<< drop;
    span = 3 * unit_of(frac);
    sel  = $urandom_range(99);
    if (sel < 50) begin
      v = longint'($urandom_range((span > 64'h7fffffff) ? 32'h7fffffff : span[31:0]));
    end else if (sel < 68) begin
      v = span + ((longint'($urandom_range(8)) - 4) * lsb) + longint'($urandom % lsb);
    end else begin
      v = longint'($signed($urandom));
    end
    if ($urandom_range(1)) v = -v;
    return clip_word(v);
  endfunction

  // idle length before the next word
  function automatic int pick_gap();
    int unsigned r;
    if ($urandom_range(39) == 0) burst_mode = !burst_mode;
    if (burst_mode) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    return $urandom_range(24, 4);
  endfunction

  // edge and special values at the current setting
  task automatic queue_edge_samples(input logic [gsp_pkg::CFG_W-1:0] frac);
    longint one, lsb;
    one = unit_of(frac);
    lsb = longint'(1) <<< ((frac > WORK_FRAC) ? frac - WORK_FRAC : 0);
    sample_q.push_back(clip_word(0));
    sample_q.push_back(clip_word(1));
    sample_q.push_back(clip_word(-1));
    sample_q.push_back({1'b0, {(DATA_WIDTH-1){1'b1}}});
    sample_q.push_back({1'b1, {(DATA_WIDTH-1){1'b0}}});
    sample_q.push_back(clip_word(3 * one));
    sample_q.push_back(clip_word(3 * one - lsb));
    sample_q.push_back(clip_word(3 * one + lsb - 1));
    sample_q.push_back(clip_word(-3 * one));
    sample_q.push_back(clip_word(-3 * one - 1));
    sample_q.push_back(clip_word(one / 2));
    sample_q.push_back(clip_word(-one / 2));
    sample_q.push_back(clip_word(-3 * one / 2));
    sample_q.push_back(clip_word(2 * one + lsb - 1));
  endtask

  // write the fraction-bits register
  task automatic write_frac_bits(input logic [gsp_pkg::CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    frac_bits = v;
  endtask

  // hold off until every word is accepted and every result is back
  task automatic drain();
    while (sample_q.size() != 0 || start || gelu_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // driver: present words from the pending queue, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      sample_i <= '0;
    end else begin
      if (start && !busy) begin
        gelu_expect_q.push_back(gelu_predict(sample_i, frac_bits));
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (sample_q.size() != 0) begin
          start    <= 1'b1;
          sample_i <= sample_q.pop_front();
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed word against the oldest prediction
  always @(posedge clk_i) begin
    logic signed [DATA_WIDTH-1:0] want;
    if (rst_ni && gelu_valid_o) begin
      if (gelu_expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %0d", $time, gelu_value_o);
      end else begin
        want = gelu_expect_q.pop_front();
        if (gelu_value_o !== want) begin
          errors++;
          $display("%0t: gelu_value mismatch, expected %0d, actual %0d",
                   $time, want, gelu_value_o);
        end
      end
    end
  end

  // stimulus phases over a sweep of fraction-bits settings
  initial begin
    logic [gsp_pkg::CFG_W-1:0] sweep [NUM_PHASES];
    int                        wait_cycles;
    sweep = '{gsp_pkg::CFG_RESET, 5'd12, 5'd24, 5'd0, 5'd31, 5'd13, 5'd17, 5'd20,
              5'($urandom_range(31)), 5'($urandom_range(31))};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    for (int p = 0; p < NUM_PHASES; p++) begin
      // first phase runs at the reset value, the rest are written
      if (p != 0) write_frac_bits(sweep[p]);
      queue_edge_samples(frac_bits);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        sample_q.push_back(pick_sample(frac_bits));
        // mid-phase pause until everything is back
        if (i == RANDOM_ITEMS / 2 && p % 3 == 1) drain();
      end
      drain();
    end

    // final wait for stragglers
    wait_cycles = 0;
    while (gelu_expect_q.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (10) @(posedge clk_i);
    if (gelu_expect_q.size() != 0) begin
      errors += gelu_expect_q.size();
      $display("%0t: %0d expected words never arrived", $time, gelu_expect_q.size());
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/gsp_pkg.sv
rtl/gsp_front.sv
rtl/gsp_queue.sv
rtl/gsp_back.sv
rtl/gelu_seg3_poly_approx.sv
tb/tb.sv
